### hw/rtl/chb_pkg.sv
package chb_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned TAB_LEN = 24;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned AXIS_W = 16;
	localparam int unsigned SCALE_SH = 8;
	localparam int unsigned XY_W = 28;
	localparam int unsigned ACC_W = 26;
	localparam int unsigned OUT_W = 16;
	localparam int unsigned RND_SH = 8;

	localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180 * 32768);
	localparam logic signed [ACC_W-1:0] FULL_TURN = ACC_W'(360 * 32768);
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(128);
	localparam logic [OUT_W-1:0] FULL_TURN_OUT = OUT_W'(46080);

	typedef struct packed {
		logic zero;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [ACC_W-1:0] acc;
	} beat_t;

	function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			0: v = ACC_W'(1474560);
			1: v = ACC_W'(870484);
			2: v = ACC_W'(459940);
			3: v = ACC_W'(233473);
			4: v = ACC_W'(117189);
			5: v = ACC_W'(58652);
			6: v = ACC_W'(29333);
			7: v = ACC_W'(14667);
			8: v = ACC_W'(7334);
			9: v = ACC_W'(3667);
			10: v = ACC_W'(1833);
			11: v = ACC_W'(917);
			12: v = ACC_W'(458);
			13: v = ACC_W'(229);
			14: v = ACC_W'(115);
			15: v = ACC_W'(57);
			16: v = ACC_W'(29);
			17: v = ACC_W'(14);
			18: v = ACC_W'(7);
			19: v = ACC_W'(4);
			20: v = ACC_W'(2);
			21: v = ACC_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/chb_pre.sv
module chb_pre (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [chb_pkg::BYTE_W-1:0] x_high,
	input logic [chb_pkg::BYTE_W-1:0] x_low,
	input logic [chb_pkg::BYTE_W-1:0] y_high,
	input logic [chb_pkg::BYTE_W-1:0] y_low,
	output logic out_valid,
	input logic out_stall,
	output chb_pkg::beat_t out_beat
);
	import chb_pkg::*;

	logic valid_q;
	beat_t beat_q;
	beat_t beat_d;
	logic signed [AXIS_W-1:0] x16;
	logic signed [AXIS_W-1:0] y16;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;

	assign x16 = {x_high, x_low};
	assign y16 = {y_high, y_low};
	assign xs = XY_W'(x16) <<< SCALE_SH;
	assign ys = XY_W'(y16) <<< SCALE_SH;

	always_comb begin
		beat_d.zero = (x16 == '0) && (y16 == '0);
		if (x16 < 0) begin
			beat_d.x = -xs;
			beat_d.y = -ys;
			beat_d.acc = HALF_TURN;
		end else begin
			beat_d.x = xs;
			beat_d.y = ys;
			beat_d.acc = '0;
		end
	end

	assign in_stall = valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_q <= beat_d;
		end
	end

	assign out_valid = valid_q;
	assign out_beat = beat_q;

endmodule

### hw/rtl/chb_cell.sv
module chb_cell #(
	parameter int unsigned STAGE = 0
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input chb_pkg::beat_t in_beat,
	output logic out_valid,
	input logic out_stall,
	output chb_pkg::beat_t out_beat
);
	import chb_pkg::*;

	localparam logic signed [ACC_W-1:0] ANGLE = atan_entry(STAGE);

	logic valid_q;
	beat_t beat_q;
	beat_t beat_d;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;

	assign dx = in_beat.y >>> STAGE;
	assign dy = in_beat.x >>> STAGE;

	always_comb begin
		beat_d.zero = in_beat.zero;
		if (in_beat.y >= 0) begin
			beat_d.x = in_beat.x + dx;
			beat_d.y = in_beat.y - dy;
			beat_d.acc = in_beat.acc + ANGLE;
		end else begin
			beat_d.x = in_beat.x - dx;
			beat_d.y = in_beat.y + dy;
			beat_d.acc = in_beat.acc - ANGLE;
		end
	end

	assign in_stall = valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_q <= beat_d;
		end
	end

	assign out_valid = valid_q;
	assign out_beat = beat_q;

endmodule

### hw/rtl/chb_post.sv
module chb_post (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input chb_pkg::beat_t in_beat,
	output logic out_valid,
	input logic out_stall,
	output logic [chb_pkg::OUT_W-1:0] heading
);
	import chb_pkg::*;

	logic valid_q;
	logic [OUT_W-1:0] heading_q;
	logic [OUT_W-1:0] heading_d;
	logic signed [ACC_W-1:0] acc_wrap;
	logic [ACC_W-1:0] acc_rnd;
	logic [OUT_W-1:0] h_raw;

	assign acc_wrap = (in_beat.acc < 0) ? in_beat.acc + FULL_TURN : in_beat.acc;
	assign acc_rnd = ACC_W'(acc_wrap) + RND_HALF;
	assign h_raw = acc_rnd[RND_SH+OUT_W-1:RND_SH];

	always_comb begin
		if (in_beat.zero) begin
			heading_d = '0;
		end else if (h_raw >= FULL_TURN_OUT) begin
			heading_d = h_raw - FULL_TURN_OUT;
		end else begin
			heading_d = h_raw;
		end
	end

	assign in_stall = valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			heading_q <= heading_d;
		end
	end

	assign out_valid = valid_q;
	assign heading = heading_q;

endmodule

### hw/rtl/compass_heading_from_bytes.sv
// Compass heading from the raw X and Y magnetometer bytes: each byte pair is
// joined into a signed 16-bit axis value and the heading atan2(y, x) is given in
// units of 1/128 degree, 0 up to 46079, with both axes zero giving 0. The block
// takes one beat per clock cycle while in_stall is low and gives one result beat
// per input beat, in order. It is built from a pre-rotation stage, one CORDIC
// cell per step (CORDIC_STEPS, capped at TAB_LEN), and a wrap-and-round stage
// holding the output register. Every stage holds its beat under stall, so a
// stalled output only halts the stages behind it once they are full.
module compass_heading_from_bytes #(
	parameter int unsigned CORDIC_STEPS = chb_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [chb_pkg::BYTE_W-1:0] x_high,
	input logic [chb_pkg::BYTE_W-1:0] x_low,
	input logic [chb_pkg::BYTE_W-1:0] y_high,
	input logic [chb_pkg::BYTE_W-1:0] y_low,
	output logic out_valid,
	input logic out_stall,
	output logic [chb_pkg::OUT_W-1:0] heading
);
	import chb_pkg::*;

	localparam int unsigned NSTEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

	beat_t link_beat [NSTEPS+1];
	logic link_valid [NSTEPS+1];
	logic link_stall [NSTEPS+1];

	chb_pre u_pre (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_high(x_high),
		.x_low(x_low),
		.y_high(y_high),
		.y_low(y_low),
		.out_valid(link_valid[0]),
		.out_stall(link_stall[0]),
		.out_beat(link_beat[0])
	);

	for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
		chb_cell #(
			.STAGE(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(link_valid[i]),
			.in_stall(link_stall[i]),
			.in_beat(link_beat[i]),
			.out_valid(link_valid[i+1]),
			.out_stall(link_stall[i+1]),
			.out_beat(link_beat[i+1])
		);
	end

	chb_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(link_valid[NSTEPS]),
		.in_stall(link_stall[NSTEPS]),
		.in_beat(link_beat[NSTEPS]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.heading(heading)
	);

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STAGES = (chb_pkg::CORDIC_STEPS_DEF > chb_pkg::TAB_LEN) ?
		chb_pkg::TAB_LEN : chb_pkg::CORDIC_STEPS_DEF;
	localparam longint DEG = 32768;
	localparam longint TURN_OUT = 46080;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] heading;
	} heading_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] x_high = '0;
	logic [7:0] x_low = '0;
	logic [7:0] y_high = '0;
	logic [7:0] y_low = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] heading;

	longint arc_table [24] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
		7334, 3667, 1833, 917, 458, 229, 115, 57,
		29, 14, 7, 4, 2, 1, 0, 0
	};

	heading_rec_t pending_headings[$];
	int mismatches = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int sink_hold_cycles = 0;

	compass_heading_from_bytes u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_high(x_high),
		.x_low(x_low),
		.y_high(y_high),
		.y_low(y_low),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.heading(heading)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [15:0] heading_from_axes(input logic signed [15:0] ax,
		input logic signed [15:0] ay);
		longint x;
		longint y;
		longint acc;
		longint dx;
		longint dy;
		longint h;
		if (ax == 0 && ay == 0)
			return 16'd0;
		x = longint'(ax) * 256;
		y = longint'(ay) * 256;
		acc = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 180 * DEG;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				acc = acc + arc_table[i];
			end else begin
				x = x - dx;
				y = y + dy;
				acc = acc - arc_table[i];
			end
		end
		if (acc < 0)
			acc = acc + 360 * DEG;
		h = (acc + 128) >>> 8;
		if (h >= TURN_OUT)
			h = h - TURN_OUT;
		return h[15:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Offers one beat and returns at the edge where it is taken, leaving valid high.
	task automatic send_axes(input logic [15:0] ax, input logic [15:0] ay);
		heading_rec_t rec;
		if (tx_idle && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_high <= ax[15:8];
		x_low <= ax[7:0];
		y_high <= ay[15:8];
		y_low <= ay[7:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rec.x = ax;
		rec.y = ay;
		rec.heading = heading_from_axes(ax, ay);
		pending_headings.push_back(rec);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_headings.size() != 0);
	endtask

	always @(posedge clk) begin
		if (sink_hold_cycles > 0) begin
			out_stall <= 1'b1;
			sink_hold_cycles--;
		end else if (rx_idle) begin
			out_stall <= ($urandom_range(0, 99) < 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		heading_rec_t rec;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_headings.size() == 0) begin
				report_mismatch($sformatf("unexpected heading %0d", heading));
			end else begin
				rec = pending_headings.pop_front();
				if (heading !== rec.heading)
					report_mismatch($sformatf("x=%h y=%h heading %0d, want %0d",
						rec.x, rec.y, heading, rec.heading));
			end
		end
	end

	task automatic test_directed();
		logic [15:0] xs [24] = '{
			16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
			16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF,
			16'h7FFF, 16'h8000, 16'h8000, 16'h0001, 16'h7FFF, 16'h8000,
			16'h0000, 16'h00FF, 16'hFF00, 16'h7FFF, 16'h0001, 16'h8000
		};
		logic [15:0] ys [24] = '{
			16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h8000,
			16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001,
			16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
			16'h0001, 16'hFF00, 16'h00FF, 16'h7FFE, 16'h7FFF, 16'h7FFF
		};
		for (int i = 0; i < 24; i++)
			send_axes(xs[i], ys[i]);
		wait_for_results();
	endtask

	task automatic test_random_mix(input int count);
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] m;
		for (int i = 0; i < count; i++) begin
			m = 16'($urandom);
			case ($urandom_range(0, 3))
				0: begin
					ax = 16'($urandom);
					ay = 16'($urandom);
				end
				1: begin
					ax = 16'($urandom_range(0, 63)) - 16'd32;
					ay = 16'($urandom_range(0, 63)) - 16'd32;
				end
				2: begin
					ax = $urandom_range(0, 1) ? 16'h0000 : m;
					ay = (ax == 16'h0000) ? m : 16'h0000;
					if ($urandom_range(0, 3) == 0)
						ay = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
				end
				default: begin
					ax = $urandom_range(0, 1) ? m : -m;
					ay = $urandom_range(0, 1) ? m : -m;
				end
			endcase
			send_axes(ax, ay);
		end
	endtask

	task automatic test_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_random_mix(100);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		wait_for_results();
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		sink_hold_cycles = 300;
		test_random_mix(60);
		tx_idle = 1'b1;
		wait_for_results();
	endtask

	task automatic test_drain_pause();
		test_random_mix(20);
		wait_for_results();
		test_random_mix(20);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(300);
		test_back_to_back();
		test_backpressure();
		test_drain_pause();
		wait_for_results();
		repeat (40) @(posedge clk);
		if (pending_headings.size() != 0)
			report_mismatch($sformatf("%0d headings never arrived",
				pending_headings.size()));
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### compass_heading_from_bytes.f
hw/rtl/chb_pkg.sv
hw/rtl/chb_pre.sv
hw/rtl/chb_cell.sv
hw/rtl/chb_post.sv
hw/rtl/compass_heading_from_bytes.sv
tb/testbench.sv
